### src/websocket_frame_deframer_assert.svh
// Assertion macros used by the deframer parser module.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsd_pkg;

   localparam int BYTE_W    = 8;
   localparam int OPCODE_W  = 4;
   localparam int LENGTH_W  = 63;
   localparam int KEY_W     = 32;
   localparam int HDRCNT_W  = 3;
   localparam int KEYIDX_W  = 2;
   localparam int RSP_DATA_W = 80;

   localparam logic [6:0] LEN_EXT16_CODE = 7'd126;
   localparam logic [6:0] LEN_EXT64_CODE = 7'd127;

   localparam logic [HDRCNT_W-1:0] EXT16_LAST_CNT = 3'd1;
   localparam logic [HDRCNT_W-1:0] EXT64_LAST_CNT = 3'd7;
   localparam logic [HDRCNT_W-1:0] KEY_LAST_CNT   = 3'd3;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // Parser phase, one-hot.
   typedef enum logic [5:0] {
      PH_HDR0  = 6'b000001,
      PH_HDR1  = 6'b000010,
      PH_EXT16 = 6'b000100,
      PH_EXT64 = 6'b001000,
      PH_KEY   = 6'b010000,
      PH_PAY   = 6'b100000
   } phase_type;

   // One result item.
   typedef struct packed {
      logic                kind;
      logic [OPCODE_W-1:0] opcode;
      logic                fin;
      logic                masked;
      logic [LENGTH_W-1:0] payload_length;
      logic [BYTE_W-1:0]   data;
      logic                last;
   } result_type;

endpackage

### src/wsd_in_stage.sv
// Input register of the deframer: holds one received byte until the parser takes it.
`timescale 1ns / 1ps
module wsd_in_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [wsd_pkg::BYTE_W-1:0] req_tdata,
   input  logic                      advance_i,
   output logic                      valid_o,
   output logic [wsd_pkg::BYTE_W-1:0] byte_o
);
   import wsd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   // Accept when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || advance_i;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (advance_i) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign valid_o = valid_ff;
   assign byte_o  = byte_ff;

endmodule

### src/wsd_parser.sv
// Frame parser: header state, extended length and key capture, payload unmasking.
`timescale 1ns / 1ps
module wsd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_i,
   input  logic [wsd_pkg::BYTE_W-1:0]  byte_i,
   output logic                        res_valid_o,
   output wsd_pkg::result_type         res_o
);
   import wsd_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [OPCODE_W-1:0]   opcode_ff, opcode_in;
   logic                  fin_ff, fin_in;
   logic                  masked_ff, masked_in;
   logic [LENGTH_W-1:0]   length_ff, length_in;
   logic [LENGTH_W-1:0]   left_ff, left_in;
   logic [HDRCNT_W-1:0]   hcnt_ff, hcnt_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [KEYIDX_W-1:0]   kidx_ff, kidx_in;

   logic                  emit_hdr;
   logic                  len_done;
   logic                  pay;
   logic                  pay_last;
   logic [BYTE_W-1:0]     key_byte;
   logic [LENGTH_W-1:0]   shifted_len;
   logic                  empty;

   assign shifted_len = {length_ff[LENGTH_W-BYTE_W-1:0], byte_i};
   assign pay_last    = (left_ff[LENGTH_W-1:1] == '0);

   // Select the key byte for this payload position, first key byte on top
   always_comb begin
      unique case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // Advance the phase for one byte
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      length_in = length_ff;
      left_in   = left_ff;
      hcnt_in   = hcnt_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      len_done  = 1'b0;
      emit_hdr  = 1'b0;
      pay       = 1'b0;

      unique case (phase_ff)
         PH_HDR1: begin
            masked_in = byte_i[7];
            hcnt_in   = '0;
            length_in = '0;
            if (byte_i[6:0] == LEN_EXT16_CODE) begin
               phase_in = PH_EXT16;
            end else if (byte_i[6:0] == LEN_EXT64_CODE) begin
               phase_in = PH_EXT64;
            end else begin
               length_in = {{(LENGTH_W-7){1'b0}}, byte_i[6:0]};
               len_done  = 1'b1;
            end
         end
         PH_EXT16, PH_EXT64: begin
            length_in = shifted_len;
            if (hcnt_ff >= ((phase_ff == PH_EXT16) ? EXT16_LAST_CNT : EXT64_LAST_CNT)) begin
               len_done = 1'b1;
            end else begin
               hcnt_in = hcnt_ff + 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[KEY_W-BYTE_W-1:0], byte_i};
            if (hcnt_ff >= KEY_LAST_CNT) begin
               emit_hdr = 1'b1;
            end else begin
               hcnt_in = hcnt_ff + 3'd1;
            end
         end
         PH_PAY: begin
            pay     = 1'b1;
            kidx_in = kidx_ff + 2'd1;
            if (left_ff != '0) begin
               left_in = left_ff - {{(LENGTH_W-1){1'b0}}, 1'b1};
            end
            if (pay_last) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            // First header byte; unused codes land here too
            fin_in    = byte_i[7];
            opcode_in = byte_i[3:0];
            masked_in = 1'b0;
            length_in = '0;
            left_in   = '0;
            hcnt_in   = '0;
            key_in    = '0;
            kidx_in   = '0;
            phase_in  = PH_HDR1;
         end
      endcase

      // Length complete: wait for the key or finish the header
      if (len_done) begin
         hcnt_in = '0;
         if (masked_in) begin
            phase_in = PH_KEY;
         end else begin
            emit_hdr = 1'b1;
         end
      end

      empty = (length_in == '0);
      if (emit_hdr) begin
         left_in  = length_in;
         kidx_in  = '0;
         hcnt_in  = '0;
         phase_in = empty ? PH_HDR0 : PH_PAY;
      end
   end

   // Build the result from the updated frame fields
   always_comb begin
      res_valid_o          = step_i && (emit_hdr || pay);
      res_o.kind           = pay ? KIND_PAYLOAD : KIND_HEADER;
      res_o.opcode         = opcode_in;
      res_o.fin            = fin_in;
      res_o.masked         = masked_in;
      res_o.payload_length = length_in;
      res_o.data           = pay ? (byte_i ^ key_byte) : '0;
      res_o.last           = pay ? pay_last : empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         length_ff <= '0;
         left_ff   <= '0;
         hcnt_ff   <= '0;
         key_ff    <= '0;
         kidx_ff   <= '0;
      end else if (step_i) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         length_ff <= length_in;
         left_ff   <= left_in;
         hcnt_ff   <= hcnt_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_in;
      end
   end

`include "websocket_frame_deframer_assert.svh"

   `WSD_ASSERT_NOW(a_pay_gives_byte, clock, reset, step_i && phase_ff == PH_PAY, res_valid_o && res_o.kind == KIND_PAYLOAD)
   `WSD_ASSERT_NOW(a_empty_hdr_len, clock, reset, res_valid_o && res_o.kind == KIND_HEADER && res_o.last, res_o.payload_length == '0)
   `WSD_ASSERT_NEXT(a_last_byte_ends, clock, reset, step_i && phase_ff == PH_PAY && pay_last, phase_ff == PH_HDR0)

endmodule

### src/websocket_frame_deframer.sv
// WebSocket frame deframer top level: input register, parser and result register.
`timescale 1ns / 1ps
// Receive-side WebSocket deframer. Feed the frame stream one byte per req item;
// a new item may follow every cycle while rsp_tready is high. Header
// bytes, extended length and masking key give no result; the completed header
// gives one rsp item with tuser = 0 (tlast set for an empty frame), and each
// payload byte gives one rsp item with tuser = 1 carrying the unmasked byte,
// tlast on the final byte. A length code of 127 takes a 64-bit length of which
// the top bit is dropped. From req accept a byte passes the input register, then
// the combinational parse stage into the result register, and rsp_tready low
// stalls it. Throughput is one byte per cycle while rsp_tready is high.
module websocket_frame_deframer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [wsd_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] in_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [3:0] opcode, [4] fin, [5] masked, [68:6] payload_length, [76:69] data, [79:77] zero
   output logic [wsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,   // [0] kind
   output logic                           rsp_tlast
);
   import wsd_pkg::*;

   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;
   logic              advance;
   logic              res_valid;
   result_type        res;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   // Move the held byte when the result register is free or draining
   assign advance = in_valid && (!rsp_valid_ff || rsp_tready);

   wsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance_i  (advance),
      .valid_o    (in_valid),
      .byte_o     (in_byte)
   );

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_i      (advance),
      .byte_i      (in_byte),
      .res_valid_o (res_valid),
      .res_o       (res)
   );

   // Load a new result or drop the delivered one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {3'b000, rsp_ff.data, rsp_ff.payload_length,
                        rsp_ff.masked, rsp_ff.fin, rsp_ff.opcode};

endmodule
